/* src/rlpse_pkg.sv */
// Shared types, constants and lookup tables for the rainbow LED SPI encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rlpse_pkg;

  localparam int LED_COUNT     = 64;
  localparam int LedCountEff   = (LED_COUNT == 0) ? 1 : LED_COUNT;
  localparam int LedIdxW       = 6;
  localparam int LedSlots      = 1 << LedIdxW;
  localparam int BYTES_PER_LED = 32;
  localparam int ByteCntW      = $clog2(BYTES_PER_LED);

  localparam logic [7:0] CODE_ONE     = 8'hF0;
  localparam logic [7:0] CODE_ZERO    = 8'h80;
  localparam logic [7:0] BRIGHT_RESET = 8'd128;
  localparam logic [7:0] WHEEL_SEG1   = 8'd85;
  localparam logic [7:0] WHEEL_SEG2   = 8'd170;
  localparam logic [7:0] CHAN_FULL    = 8'd255;

  typedef enum logic {
    OP_RAINBOW = 1'b0,
    OP_SOLID   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } rgbw_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic       valid;
    logic       solid;
    logic [7:0] wheel_pos;
    rgbw_t      color;
  } hue_stage_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic  valid;
    logic  solid;
    rgbw_t color;
  } wheel_stage_t;

  // stage 3 -> serializer, word in green, red, blue, white order
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } pixel_stage_t;

  typedef logic [LedSlots-1:0][7:0] hue_table_t;

  function automatic hue_table_t build_hue_table();
    hue_table_t t;
    for (int i = 0; i < LedSlots; i++) begin
      t[i] = 8'((i * 256) / LedCountEff);
    end
    return t;
  endfunction

  localparam hue_table_t HUE_OFFSET = build_hue_table();

endpackage

`default_nettype wire

/* src/rlpse_hue.sv */
// Stage 1: hue offset lookup and base hue add, yields the wheel position.
// Depends on rlpse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpse_hue
  import rlpse_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output      logic               ready_o,
  input  wire logic               opcode_i,
  input  wire logic [LedIdxW-1:0] led_index_i,
  input  wire logic [7:0]         base_hue_i,
  input  wire rgbw_t              color_i,
  output      hue_stage_t         out_o,
  input  wire logic               ready_i
);

  logic       valid_q;
  logic       solid_q, solid_d;
  logic [7:0] pos_q, pos_d;
  rgbw_t      color_q;
  logic [7:0] hue;

  assign ready_o = !valid_q || ready_i;
  assign hue     = base_hue_i + HUE_OFFSET[led_index_i];
  assign pos_d   = CHAN_FULL - hue;
  assign solid_d = (opcode_e'(opcode_i) == OP_SOLID);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      solid_q <= solid_d;
      pos_q   <= pos_d;
      color_q <= color_i;
    end
  end

  assign out_o = '{valid: valid_q, solid: solid_q, wheel_pos: pos_q, color: color_q};

endmodule

`default_nettype wire

/* src/rlpse_wheel.sv */
// Stage 2: three-segment color wheel, maps the wheel position to red, green, blue.
// Depends on rlpse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpse_wheel
  import rlpse_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire hue_stage_t   in_i,
  output      logic         ready_o,
  output      wheel_stage_t out_o,
  input  wire logic         ready_i
);

  logic       valid_q;
  logic       solid_q;
  rgbw_t      color_q, color_d;
  logic [7:0] seg_pos;
  logic [9:0] ramp_w;
  logic [7:0] ramp_up, ramp_dn;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (in_i.wheel_pos < WHEEL_SEG1) begin
      seg_pos = in_i.wheel_pos;
    end else if (in_i.wheel_pos < WHEEL_SEG2) begin
      seg_pos = in_i.wheel_pos - WHEEL_SEG1;
    end else begin
      seg_pos = in_i.wheel_pos - WHEEL_SEG2;
    end
  end

  assign ramp_w  = {2'b00, seg_pos} + {1'b0, seg_pos, 1'b0};
  assign ramp_up = ramp_w[7:0];
  assign ramp_dn = CHAN_FULL - ramp_up;

  always_comb begin
    color_d = in_i.color;
    if (!in_i.solid) begin
      color_d.white = 8'd0;
      if (in_i.wheel_pos < WHEEL_SEG1) begin
        color_d.red   = ramp_dn;
        color_d.green = 8'd0;
        color_d.blue  = ramp_up;
      end else if (in_i.wheel_pos < WHEEL_SEG2) begin
        color_d.red   = 8'd0;
        color_d.green = ramp_up;
        color_d.blue  = ramp_dn;
      end else begin
        color_d.red   = ramp_up;
        color_d.green = ramp_dn;
        color_d.blue  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_i.valid) begin
      solid_q <= in_i.solid;
      color_q <= color_d;
    end
  end

  assign out_o = '{valid: valid_q, solid: solid_q, color: color_q};

endmodule

`default_nettype wire

/* src/rlpse_dim.sv */
// Stage 3: brightness scaling of rainbow colors and packing in green, red, blue,
// white order. Depends on rlpse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpse_dim
  import rlpse_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [7:0]   brightness_i,
  input  wire wheel_stage_t in_i,
  output      logic         ready_o,
  output      pixel_stage_t out_o,
  input  wire logic         ready_i
);

  logic        valid_q;
  logic [31:0] word_q, word_d;
  logic [15:0] prod_r, prod_g, prod_b;

  assign ready_o = !valid_q || ready_i;

  assign prod_r = 16'(in_i.color.red)   * 16'(brightness_i);
  assign prod_g = 16'(in_i.color.green) * 16'(brightness_i);
  assign prod_b = 16'(in_i.color.blue)  * 16'(brightness_i);

  always_comb begin
    if (in_i.solid) begin
      word_d = {in_i.color.green, in_i.color.red, in_i.color.blue, in_i.color.white};
    end else begin
      word_d = {prod_g[15:8], prod_r[15:8], prod_b[15:8], 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && in_i.valid) begin
      word_q <= word_d;
    end
  end

  assign out_o = '{valid: valid_q, word: word_q};

endmodule

`default_nettype wire

/* src/rlpse_serializer.sv */
// Output stage: shifts one pixel word out MSB first, one coded SPI byte per cycle.
// Depends on rlpse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpse_serializer
  import rlpse_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire pixel_stage_t in_i,
  output      logic         ready_o,
  output      logic         strobe_o,
  output      logic [7:0]   spi_byte_o,
  output      logic         last_byte_o
);

  logic                active_q, active_d;
  logic [ByteCntW-1:0] cnt_q, cnt_d;
  logic [31:0]         word_q, word_d;
  logic                at_last;

  assign at_last = (cnt_q == ByteCntW'(BYTES_PER_LED - 1));
  assign ready_o = !active_q || at_last;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    word_d   = word_q;
    if (ready_o && in_i.valid) begin
      // load next pixel
      active_d = 1'b1;
      cnt_d    = '0;
      word_d   = in_i.word;
    end else if (active_q) begin
      // advance one bit
      active_d = !at_last;
      cnt_d    = cnt_q + 1'b1;
      word_d   = {word_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign strobe_o    = active_q;
  assign spi_byte_o  = word_q[31] ? CODE_ONE : CODE_ZERO;
  assign last_byte_o = active_q && at_last;

endmodule

`default_nettype wire

/* src/rainbow_led_pixel_spi_encoder.sv */
// The first SPI byte of a start transfer reaches the outputs through the hue, wheel and dim
// stage registers and the serializer register when the serializer is free; the remaining 31
// bytes follow on consecutive cycles. Throughput: set by the one-byte-per-cycle serializer;
// three register stages ahead of it buffer up to three further LEDs.
// Reset: asynchronous active low; empties the pipeline and sets brightness to 128.
// Depends on rlpse_pkg and the rlpse stage modules.
`timescale 1ns / 1ps
`default_nettype none

module rainbow_led_pixel_spi_encoder
  import rlpse_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic               opcode_i,
  input  wire logic [LedIdxW-1:0] led_index_i,
  input  wire logic [7:0]         base_hue_i,
  input  wire logic [7:0]         red_i,
  input  wire logic [7:0]         green_i,
  input  wire logic [7:0]         blue_i,
  input  wire logic [7:0]         white_i,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  output      logic               strobe_o,
  output      logic [7:0]         spi_byte_o,
  output      logic               last_byte_o
);

  logic [7:0]   bright_q;
  logic         hue_ready, wheel_ready, dim_ready, ser_ready;
  hue_stage_t   hue_out;
  wheel_stage_t wheel_out;
  pixel_stage_t dim_out;
  rgbw_t        color_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RESET;
    end else if (cfg_we_i) begin
      bright_q <= cfg_wdata_i;
    end
  end

  assign busy         = !hue_ready;
  assign color_in     = '{red: red_i, green: green_i, blue: blue_i, white: white_i};

  rlpse_hue u_hue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start),
    .ready_o     (hue_ready),
    .opcode_i    (opcode_i),
    .led_index_i (led_index_i),
    .base_hue_i  (base_hue_i),
    .color_i     (color_in),
    .out_o       (hue_out),
    .ready_i     (wheel_ready)
  );

  rlpse_wheel u_wheel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (hue_out),
    .ready_o (wheel_ready),
    .out_o   (wheel_out),
    .ready_i (dim_ready)
  );

  rlpse_dim u_dim (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .brightness_i (bright_q),
    .in_i         (wheel_out),
    .ready_o      (dim_ready),
    .out_o        (dim_out),
    .ready_i      (ser_ready)
  );

  rlpse_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (dim_out),
    .ready_o     (ser_ready),
    .strobe_o    (strobe_o),
    .spi_byte_o  (spi_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

/* src/rlpse_checker.sv */
// Port-level checks on the SPI byte stream of the encoder top level, and the
// bind that attaches them. Depends on rlpse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpse_checker
  import rlpse_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       strobe_o,
  input wire logic [7:0] spi_byte_o,
  input wire logic       last_byte_o
);

  a_last_needs_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> strobe_o)
    else $error("last byte flagged without strobe");

  a_byte_coded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (spi_byte_o == CODE_ONE || spi_byte_o == CODE_ZERO))
    else $error("SPI byte is not a valid bit code");

  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_byte_o) |=> strobe_o)
    else $error("byte burst broken before last byte");

  a_burst_ends_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(strobe_o) |-> $past(last_byte_o))
    else $error("byte burst ended without last byte");

endmodule

bind rainbow_led_pixel_spi_encoder rlpse_checker u_rlpse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .strobe_o    (strobe_o),
  .spi_byte_o  (spi_byte_o),
  .last_byte_o (last_byte_o)
);

`default_nettype wire

/* tb/rainbow_led_pixel_spi_encoder_test.sv */
// Self-checking testbench for rainbow_led_pixel_spi_encoder: predicts the 32 coded SPI
// bytes of every LED transfer (rainbow wheel with brightness, or solid RGBW) and checks them.
// Depends on rlpse_pkg and the encoder RTL.
`timescale 1ns / 1ps

module rainbow_led_pixel_spi_encoder_test;
  import rlpse_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } spi_byte_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               opcode_i;
  logic [LedIdxW-1:0] led_index_i;
  logic [7:0]         base_hue_i;
  logic [7:0]         red_i;
  logic [7:0]         green_i;
  logic [7:0]         blue_i;
  logic [7:0]         white_i;
  logic               cfg_we_i;
  logic [7:0]         cfg_wdata_i;
  logic               strobe_o;
  logic [7:0]         spi_byte_o;
  logic               last_byte_o;

  spi_byte_t   pending_bytes[$];
  logic [7:0]  brightness_model;
  int          mismatch_count = 0;
  int          bytes_checked = 0;
  int          leds_sent = 0;
  int          rainbow_sent = 0;
  int          cycle_count = 0;
  bit          no_gaps = 1'b0;

  rainbow_led_pixel_spi_encoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .led_index_i(led_index_i),
    .base_hue_i (base_hue_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .white_i    (white_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .strobe_o   (strobe_o),
    .spi_byte_o (spi_byte_o),
    .last_byte_o(last_byte_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAIL rainbow_led_pixel_spi_encoder");
      $finish;
    end
  end

  // Check each SPI byte against the oldest predicted one.
  always @(posedge clk_i) begin
    spi_byte_t exp_byte;
    if (strobe_o === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected byte: expected none, actual spi_byte=%h last_byte=%b",
                 $time, spi_byte_o, last_byte_o);
      end else begin
        exp_byte = pending_bytes.pop_front();
        bytes_checked++;
        if (spi_byte_o !== exp_byte.code) begin
          mismatch_count++;
          $display("%0t: spi_byte mismatch: expected %h actual %h",
                   $time, exp_byte.code, spi_byte_o);
        end
        if (last_byte_o !== exp_byte.last) begin
          mismatch_count++;
          $display("%0t: last_byte mismatch: expected %b actual %b",
                   $time, exp_byte.last, last_byte_o);
        end
      end
    end
  end

  // Colour word in green, red, blue, white order.
  function automatic logic [31:0] pixel_grbw(opcode_e op, logic [LedIdxW-1:0] idx,
                                             logic [7:0] base, logic [7:0] r_in,
                                             logic [7:0] g_in, logic [7:0] b_in,
                                             logic [7:0] w_in, logic [7:0] bright);
    int         chain_len;
    logic [7:0] hue;
    logic [7:0] p;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    if (op == OP_SOLID) return {g_in, r_in, b_in, w_in};
    chain_len = (LED_COUNT == 0) ? 1 : LED_COUNT;
    hue = base + 8'((int'(idx) * 256) / chain_len);
    p = 8'd255 - hue;
    if (p < 8'd85) begin
      r = 8'd255 - p * 8'd3;
      g = 8'd0;
      b = p * 8'd3;
    end else if (p < 8'd170) begin
      p = p - 8'd85;
      r = 8'd0;
      g = p * 8'd3;
      b = 8'd255 - p * 8'd3;
    end else begin
      p = p - 8'd170;
      r = p * 8'd3;
      g = 8'd255 - p * 8'd3;
      b = 8'd0;
    end
    prod_r = 16'(r) * 16'(bright);
    prod_g = 16'(g) * 16'(bright);
    prod_b = 16'(b) * 16'(bright);
    return {prod_g[15:8], prod_r[15:8], prod_b[15:8], 8'd0};
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(11, 0));
  endfunction

  task automatic send_led(opcode_e op, logic [LedIdxW-1:0] idx, logic [7:0] base,
                          logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] w,
                          int gap);
    logic [31:0] word;
    spi_byte_t   sb;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    led_index_i <= idx;
    base_hue_i  <= base;
    red_i       <= r;
    green_i     <= g;
    blue_i      <= b;
    white_i     <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    word = pixel_grbw(op, idx, base, r, g, b, w, brightness_model);
    for (int k = 0; k < BYTES_PER_LED; k++) begin
      sb.code = word[31-k] ? CODE_ONE : CODE_ZERO;
      sb.last = (k == BYTES_PER_LED - 1);
      pending_bytes.push_back(sb);
    end
    leds_sent++;
    if (op == OP_RAINBOW) rainbow_sent++;
  endtask

  task automatic send_random_led();
    opcode_e op;
    op = $urandom_range(1, 0) ? OP_SOLID : OP_RAINBOW;
    send_led(op, LedIdxW'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), draw_gap());
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    drop_start();
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_brightness(logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    brightness_model = value;
  endtask

  task automatic test_solid_extremes();
    send_led(OP_SOLID, '0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_led(OP_SOLID, '1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    send_led(OP_SOLID, 6'h2A, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 3);
    send_led(OP_SOLID, 6'h15, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 0);
    send_led(OP_SOLID, 6'h01, 8'h80, 8'h01, 8'h80, 8'h01, 8'h80, 7);
    send_led(OP_SOLID, 6'h3E, 8'h7F, 8'hFE, 8'h7F, 8'hFE, 8'h7F, 0);
  endtask

  // Hue points at the colour wheel segment edges, plus ignored solid fields.
  task automatic test_rainbow_wheel();
    logic [7:0] hues[10] = '{8'd0, 8'd1, 8'd84, 8'd85, 8'd86, 8'd169,
                             8'd170, 8'd171, 8'd254, 8'd255};
    foreach (hues[i]) send_led(OP_RAINBOW, '0, hues[i], 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), i % 3);
    send_led(OP_RAINBOW, '1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
    send_led(OP_RAINBOW, '1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1);
    send_led(OP_RAINBOW, 6'd32, 8'd200, 8'h00, 8'h00, 8'h00, 8'h00, 0);
  endtask

  task automatic test_brightness_extremes();
    set_brightness(8'd0);
    send_led(OP_RAINBOW, 6'd5, 8'd40, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_led(OP_SOLID, 6'd5, 8'd40, 8'hC3, 8'h3C, 8'hF0, 8'h0F, 0);
    set_brightness(8'd255);
    send_led(OP_RAINBOW, 6'd0, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_led(OP_RAINBOW, 6'd63, 8'd86, 8'h00, 8'h00, 8'h00, 8'h00, 2);
  endtask

  task automatic test_random_phases();
    logic [7:0] levels[6];
    levels = '{8'd1, 8'd128, 8'($urandom), 8'd255, 8'($urandom), 8'd0};
    foreach (levels[i]) begin
      set_brightness(levels[i]);
      no_gaps = (i == 2);
      repeat (75) send_random_led();
    end
    no_gaps = 1'b0;
  endtask

  // Hold off until all bytes are out, then resume back to back.
  task automatic test_drain_pause();
    repeat (4) send_random_led();
    wait_drained();
    no_gaps = 1'b1;
    repeat (4) send_random_led();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    opcode_i    <= OP_RAINBOW;
    led_index_i <= '0;
    base_hue_i  <= '0;
    red_i       <= '0;
    green_i     <= '0;
    blue_i      <= '0;
    white_i     <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    brightness_model = BRIGHT_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rainbow_wheel();
    test_solid_extremes();
    test_brightness_extremes();
    test_drain_pause();
    test_random_phases();

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d LEDs (%0d rainbow), %0d SPI bytes checked, %0d mismatches.",
             leds_sent, rainbow_sent, bytes_checked, mismatch_count);
    $display("Brightness taken through reset value, 0, 1, 255 and random levels.");
    if (mismatch_count == 0 && pending_bytes.size() == 0) begin
      $display("PASS rainbow_led_pixel_spi_encoder");
    end else begin
      $display("FAIL rainbow_led_pixel_spi_encoder");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rlpse_pkg.sv
src/rlpse_hue.sv
src/rlpse_wheel.sv
src/rlpse_dim.sv
src/rlpse_serializer.sv
src/rainbow_led_pixel_spi_encoder.sv
src/rlpse_checker.sv
tb/rainbow_led_pixel_spi_encoder_test.sv
